[hw/rtl/bds_pkg.sv]
// shared types and constants of the 2x2 box downscaler
`default_nettype none
package bds_pkg;

    localparam int SRC_WIDTH      = 640;
    localparam int SRC_HEIGHT     = 480;
    localparam int OUT_WIDTH      = SRC_WIDTH / 2;
    localparam int LB_SRC_ROWS    = 360;
    localparam int LB_OFFSET_ROWS = 30;

    localparam int PIX_W   = 8;
    localparam int PAIR_W  = PIX_W + 1;
    localparam int ADDR_W  = 17;
    localparam int COL_W   = $clog2(SRC_WIDTH);
    localparam int MAX_ROWS = (SRC_HEIGHT > LB_SRC_ROWS) ? SRC_HEIGHT : LB_SRC_ROWS;
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int HALF_W  = ROW_W - 1;
    localparam int SLOT_W  = $clog2(OUT_WIDTH);

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [PAIR_W-1:0] pair_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef logic [SLOT_W-1:0] slot_t;

    localparam col_t  COL_LAST       = col_t'(SRC_WIDTH - 1);
    localparam row_t  NORM_ROWS      = row_t'(SRC_HEIGHT);
    localparam row_t  LB_ROWS        = row_t'(LB_SRC_ROWS);
    localparam half_t NORM_LAST_HALF = half_t'(SRC_HEIGHT / 2 - 1);
    localparam half_t LB_LAST_HALF   = half_t'(LB_SRC_ROWS / 2 - 1);
    localparam slot_t SLOT_LAST      = slot_t'(OUT_WIDTH - 1);
    localparam addr_t OUT_WIDTH_A    = addr_t'(OUT_WIDTH);
    localparam addr_t LB_OFFSET_A    = addr_t'(LB_OFFSET_ROWS);

    typedef struct packed {
        pix_t pixel;
        logic frame_start;
    } src_beat_t;

    typedef struct packed {
        pix_t  out_pixel;
        addr_t out_address;
        logic  last;
    } dst_beat_t;

    typedef struct packed {
        logic  produce;
        logic  store_we;
        slot_t slot;
        pair_t pair;
        addr_t address;
        logic  last;
    } scan_req_t;

endpackage
`default_nettype wire

[hw/rtl/bds_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module bds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[hw/rtl/bds_scan.sv]
// raster counters, pair sums and line store control of the downscaler
`default_nettype none
module bds_scan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                accept,
    input  wire bds_pkg::src_beat_t  beat,
    output bds_pkg::scan_req_t       req
);

    logic             mode_reg, mode_next;
    bds_pkg::col_t    col_reg, col_next;
    bds_pkg::row_t    row_reg, row_next;
    bds_pkg::pix_t    pending_reg, pending_next;

    bds_pkg::col_t    col_cur;
    bds_pkg::row_t    row_cur;
    bds_pkg::row_t    rows_lim;
    bds_pkg::half_t   row_half;
    bds_pkg::half_t   last_half;
    bds_pkg::addr_t   offset_rows;
    bds_pkg::addr_t   row_addr;
    logic             active;
    logic             odd_col;
    logic             odd_row;

    assign col_cur     = beat.frame_start ? '0 : col_reg;
    assign row_cur     = beat.frame_start ? '0 : row_reg;
    assign rows_lim    = mode_reg ? bds_pkg::LB_ROWS : bds_pkg::NORM_ROWS;
    assign last_half   = mode_reg ? bds_pkg::LB_LAST_HALF : bds_pkg::NORM_LAST_HALF;
    assign offset_rows = mode_reg ? bds_pkg::LB_OFFSET_A : '0;
    assign active      = row_cur < rows_lim;
    assign odd_col     = col_cur[0];
    assign odd_row     = row_cur[0];
    assign row_half    = row_cur[bds_pkg::ROW_W-1:1];
    assign row_addr    = offset_rows + bds_pkg::addr_t'(row_half);

    always_comb
    begin
        req.slot     = bds_pkg::slot_t'(col_cur >> 1);
        req.pair     = bds_pkg::pair_t'(pending_reg) + bds_pkg::pair_t'(beat.pixel);
        req.store_we = accept && active && odd_col && !odd_row;
        req.produce  = accept && active && odd_col && odd_row;
        req.address  = row_addr * bds_pkg::OUT_WIDTH_A + bds_pkg::addr_t'(req.slot);
        req.last     = (row_half == last_half) && (req.slot == bds_pkg::SLOT_LAST);
    end

    always_comb
    begin
        mode_next    = cfg_we ? cfg_wdata : mode_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        pending_next = pending_reg;
        if (accept)
        begin
            if (beat.frame_start)
            begin
                col_next     = '0;
                row_next     = '0;
                pending_next = '0;
            end
            if (active)
            begin
                if (!odd_col)
                begin
                    pending_next = beat.pixel;
                end
                if (col_cur == bds_pkg::COL_LAST)
                begin
                    col_next = '0;
                    row_next = row_cur + 1'b1;
                end
                else
                begin
                    col_next = col_cur + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            pending_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pending_reg <= pending_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/bds_acc.sv]
// line store sum, mean and output register stage of the downscaler
`default_nettype none
module bds_acc (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire bds_pkg::scan_req_t  req,
    input  wire bds_pkg::pair_t      line_pair,
    output logic                     in_ready,
    output logic                     dst_valid,
    input  wire logic                dst_ready,
    output bds_pkg::dst_beat_t       dst_beat
);

    logic               s1_valid_reg, s1_valid_next;
    bds_pkg::pair_t     s1_pair_reg;
    bds_pkg::addr_t     s1_addr_reg;
    logic               s1_last_reg;
    logic               out_valid_reg, out_valid_next;
    bds_pkg::dst_beat_t out_beat_reg, out_beat_next;
    logic               advance;
    logic [bds_pkg::PAIR_W:0] sum;

    assign advance  = !out_valid_reg || dst_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign sum      = {1'b0, line_pair} + {1'b0, s1_pair_reg};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = req.produce;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_beat_next.out_pixel   = sum[bds_pkg::PAIR_W:2];
                out_beat_next.out_address = s1_addr_reg;
                out_beat_next.last        = s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept && req.produce)
        begin
            s1_pair_reg <= req.pair;
            s1_addr_reg <= req.address;
            s1_last_reg <= req.last;
        end
        out_beat_reg <= out_beat_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_beat  = out_beat_reg;

endmodule
`default_nettype wire

[hw/rtl/box_downscale_2x2_core.sv]
// top level of the 2x2 box downscaler
// the odd-row source beat that completes a result passes stage 1, then the output register
// throughput: one source beat per cycle; input stalls only while both stages hold a waiting beat
// reset: counters, mode and pipeline valid flags clear; the line store is not cleared
// and each entry is written on an even row before the odd row reads it
`default_nettype none
module box_downscale_2x2_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                src_valid,
    output logic                     src_ready,
    input  wire bds_pkg::src_beat_t  src_beat,
    output logic                     dst_valid,
    input  wire logic                dst_ready,
    output bds_pkg::dst_beat_t       dst_beat
);

    logic               accept;
    bds_pkg::scan_req_t req;
    bds_pkg::pair_t     line_pair;

    assign accept = src_valid && src_ready;

    bds_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .beat      (src_beat),
        .req       (req)
    );

    bds_ram #(
        .WIDTH (bds_pkg::PAIR_W),
        .DEPTH (bds_pkg::OUT_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (req.store_we),
        .waddr (req.slot),
        .wdata (req.pair),
        .re    (req.produce),
        .raddr (req.slot),
        .rdata (line_pair)
    );

    bds_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .line_pair (line_pair),
        .in_ready  (src_ready),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_beat  (dst_beat)
    );

endmodule
`default_nettype wire
